// File: hw/rtl/rns_pkg.sv
`timescale 1ns / 1ps

package rns_pkg;

	localparam int STORE_PIXELS_DEF = 131072;
	localparam int MAX_DIM          = 1024;

	localparam int REG_W     = 11;
	localparam int COORD_W   = 10;
	localparam int IDX_W     = 17;
	localparam int PIX_W     = 16;
	localparam int STAT_W    = 2;
	localparam int CFG_IDX_W = 3;

	// stream payload widths, padded to whole bytes
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 24;

	// map numerator is coord * (size - 1), quotient divided by (dest size - 1)
	localparam int NUM_W  = COORD_W + REG_W;
	localparam int FRAME_W = 2 * REG_W;
	localparam int ADDR_W  = 2 * REG_W + 1;

	typedef logic [CFG_IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_SRC_W   = 3'd0;
	localparam reg_idx_t REG_SRC_H   = 3'd1;
	localparam reg_idx_t REG_PITCH   = 3'd2;
	localparam reg_idx_t REG_DST_W   = 3'd3;
	localparam reg_idx_t REG_DST_H   = 3'd4;

	localparam logic [REG_W-1:0] SRC_W_RST = 11'd320;
	localparam logic [REG_W-1:0] SRC_H_RST = 11'd240;
	localparam logic [REG_W-1:0] PITCH_RST = 11'd320;
	localparam logic [REG_W-1:0] DST_W_RST = 11'd160;
	localparam logic [REG_W-1:0] DST_H_RST = 11'd120;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_SIZE  = 2'd1,
		STAT_RANGE = 2'd2
	} stat_t;

	function automatic logic size_ok(input logic [REG_W-1:0] v);
		return (v != '0) && (32'(v) <= 32'(MAX_DIM));
	endfunction

endpackage

// File: hw/rtl/rgb565_nearest_scaler.sv
`timescale 1ns / 1ps
// load transfer: written to the frame store in the accept cycle, next item the cycle after
// fetch transfer: check, frame, divide, address and done states; next item taken once the
//   result enters the output register; x and y 21-step bit-serial dividers run in parallel
// errors (bad sizes, coordinate out of range) skip the division, going from frame to done
// async reset clears control and loads the register defaults; the frame store is not cleared
module rgb565_nearest_scaler
	import rns_pkg::*;
#(
	parameter int STORE_PIXELS = STORE_PIXELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// load_index[16:0], load_pixel[32:17], dest_x[42:33], dest_y[52:43], zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// op[0]
	input  logic [0:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// out_pixel[15:0], status[17:16], zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [REG_W-1:0]      cfg_data
);

	localparam int AW = $clog2(STORE_PIXELS);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CHECK = 6'b000010,
		ST_FRAME = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_ADDR  = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q;

	logic [REG_W-1:0] src_w_q, src_h_q, pitch_cfg_q, dst_w_q, dst_h_q;

	logic               in_op;
	logic [IDX_W-1:0]   in_index;
	logic [PIX_W-1:0]   in_pixel;
	logic [COORD_W-1:0] in_x, in_y;
	logic               in_xfer;

	logic [COORD_W-1:0] dx_q, dy_q;
	logic               size_bad_q, coord_bad_q;
	logic [REG_W-1:0]   pitch_q;
	logic [FRAME_W-1:0] frame_q;
	logic [NUM_W-1:0]   num_x_q, num_y_q;
	logic [ADDR_W-1:0]  addr_q;
	stat_t              status_q;

	logic [REG_W-1:0]   pitch;
	logic               sizes_ok;
	logic               frame_big;
	logic               addr_bad;

	logic               div_start;
	logic               div_busy_x, div_busy_y;
	logic               div_done_x, div_done_y;
	logic [NUM_W-1:0]   quo_x, quo_y;
	logic [REG_W-1:0]   sx, sy;

	logic               ram_we, ram_re;
	logic [PIX_W-1:0]   ram_rdata;

	logic               out_valid_q;
	logic [PIX_W-1:0]   out_pixel_q;
	stat_t              out_status_q;
	logic               out_load;

	assign in_index = s_axis_tdata[16:0];
	assign in_pixel = s_axis_tdata[32:17];
	assign in_x     = s_axis_tdata[42:33];
	assign in_y     = s_axis_tdata[52:43];
	assign in_op    = s_axis_tuser[0];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q     <= SRC_W_RST;
			src_h_q     <= SRC_H_RST;
			pitch_cfg_q <= PITCH_RST;
			dst_w_q     <= DST_W_RST;
			dst_h_q     <= DST_H_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SRC_W: src_w_q     <= cfg_data;
				REG_SRC_H: src_h_q     <= cfg_data;
				REG_PITCH: pitch_cfg_q <= cfg_data;
				REG_DST_W: dst_w_q     <= cfg_data;
				REG_DST_H: dst_h_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign pitch     = (pitch_cfg_q < src_w_q) ? src_w_q : pitch_cfg_q;
	assign sizes_ok  = size_ok(src_w_q) && size_ok(src_h_q) &&
		size_ok(dst_w_q) && size_ok(dst_h_q);
	assign frame_big = 32'(frame_q) > 32'(STORE_PIXELS);
	assign addr_bad  = 32'(addr_q) >= 32'(STORE_PIXELS);

	// destination size of one picks the center line
	assign sx = (dst_w_q == REG_W'(1)) ? (src_w_q >> 1) : quo_x[REG_W-1:0];
	assign sy = (dst_h_q == REG_W'(1)) ? (src_h_q >> 1) : quo_y[REG_W-1:0];

	assign div_start = (state_q == ST_FRAME) && !size_bad_q && !frame_big && !coord_bad_q;
	assign ram_we    = in_xfer && (in_op == OP_LOAD) &&
		(32'(in_index) < 32'(STORE_PIXELS));
	assign ram_re    = (state_q == ST_ADDR) && !addr_bad;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && in_op == OP_FETCH) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: state_q <= ST_FRAME;
				ST_FRAME: state_q <= div_start ? ST_DIV : ST_DONE;
				ST_DIV: begin
					if (div_done_x) begin
						state_q <= ST_ADDR;
					end
				end
				ST_ADDR: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			dx_q <= in_x;
			dy_q <= in_y;
		end
		if (state_q == ST_CHECK) begin
			size_bad_q  <= !sizes_ok;
			coord_bad_q <= ({1'b0, dx_q} >= dst_w_q) || ({1'b0, dy_q} >= dst_h_q);
			pitch_q     <= pitch;
			frame_q     <= FRAME_W'(src_h_q) * FRAME_W'(pitch);
			num_x_q     <= NUM_W'(dx_q) * NUM_W'(src_w_q - REG_W'(1));
			num_y_q     <= NUM_W'(dy_q) * NUM_W'(src_h_q - REG_W'(1));
		end
		if (state_q == ST_FRAME) begin
			if (size_bad_q || frame_big) begin
				status_q <= STAT_SIZE;
			end else if (coord_bad_q) begin
				status_q <= STAT_RANGE;
			end else begin
				status_q <= STAT_OK;
			end
		end
		if (state_q == ST_DIV && div_done_x) begin
			addr_q <= ADDR_W'(sy) * ADDR_W'(pitch_q) + ADDR_W'(sx);
		end
		if (state_q == ST_ADDR && addr_bad) begin
			status_q <= STAT_SIZE;
		end
	end

	rns_divider #(
		.NW(NUM_W),
		.DW(REG_W)
	) u_div_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(num_x_q),
		.divisor (dst_w_q - REG_W'(1)),
		.busy    (div_busy_x),
		.done    (div_done_x),
		.quotient(quo_x)
	);

	rns_divider #(
		.NW(NUM_W),
		.DW(REG_W)
	) u_div_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(num_y_q),
		.divisor (dst_h_q - REG_W'(1)),
		.busy    (div_busy_y),
		.done    (div_done_y),
		.quotient(quo_y)
	);

	rns_ram #(
		.WIDTH(PIX_W),
		.DEPTH(STORE_PIXELS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(in_index)),
		.wdata(in_pixel),
		.re   (ram_re),
		.raddr(addr_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	// output register frees the engine while a result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pixel_q  <= (status_q == STAT_OK) ? ram_rdata : '0;
			out_status_q <= status_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_status_q, out_pixel_q};

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(div_done_x == div_done_y) && (div_busy_x == div_busy_y))
		else $error("axis dividers out of step");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done_x |-> (state_q == ST_DIV))
		else $error("division finished outside the divide state");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result appeared without a finished fetch");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_IDLE) && !ram_re)
		else $error("store write overlaps a fetch");

endmodule

// File: hw/rtl/rns_ram.sv
`timescale 1ns / 1ps

module rns_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/rns_divider.sv
`timescale 1ns / 1ps

module rns_divider #(
	parameter int NW = 21,
	parameter int DW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          busy,
	output logic          done,
	output logic [NW-1:0] quotient
);

	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] dvs_q;

	logic [DW:0]   rem_sh;
	logic [DW+1:0] diff;
	logic          fits;

	// restoring division, one quotient bit per cycle
	assign rem_sh = {rem_q, quo_q[NW-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign fits   = !diff[DW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DW-1:0] : rem_sh[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: verif/rgb565_nearest_scaler_tb.sv
`timescale 1ns / 1ps

module rgb565_nearest_scaler_tb;
	import rns_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	// settle margin after the last result, long enough for a fetch or a load to finish
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		logic [PIX_W-1:0] pixel;
		stat_t            status;
	} scaled_px_t;

	class scaler_scoreboard;
		logic [REG_W-1:0] regs [5];
		bit [PIX_W-1:0]   store [STORE_PIXELS_DEF];
		bit               written [STORE_PIXELS_DEF];
		scaled_px_t       predicted_px [$];
		int               errors;

		function new();
			regs[REG_SRC_W] = SRC_W_RST;
			regs[REG_SRC_H] = SRC_H_RST;
			regs[REG_PITCH] = PITCH_RST;
			regs[REG_DST_W] = DST_W_RST;
			regs[REG_DST_H] = DST_H_RST;
			errors = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [REG_W-1:0] v);
			case (idx)
				REG_SRC_W, REG_SRC_H, REG_PITCH, REG_DST_W, REG_DST_H: regs[idx] = v;
				default: ;
			endcase
		endfunction

		function bit dim_valid(int unsigned v);
			return v != 0 && v <= MAX_DIM;
		endfunction

		// status of a fetch at (x, y) and, when ok, the store entry it reads
		function stat_t fetch_target(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
				output int unsigned addr);
			int unsigned sw, sh, dw, dh, pitch, xi, yi, sx, sy;
			sw = regs[REG_SRC_W];
			sh = regs[REG_SRC_H];
			dw = regs[REG_DST_W];
			dh = regs[REG_DST_H];
			xi = x;
			yi = y;
			addr = 0;
			if (!dim_valid(sw) || !dim_valid(sh) || !dim_valid(dw) || !dim_valid(dh))
				return STAT_SIZE;
			pitch = (regs[REG_PITCH] < sw) ? sw : regs[REG_PITCH];
			if (sh * pitch > STORE_PIXELS_DEF)
				return STAT_SIZE;
			if (xi >= dw || yi >= dh)
				return STAT_RANGE;
			sx = (dw == 1) ? sw / 2 : xi * (sw - 1) / (dw - 1);
			sy = (dh == 1) ? sh / 2 : yi * (sh - 1) / (dh - 1);
			addr = sy * pitch + sx;
			if (addr >= STORE_PIXELS_DEF)
				return STAT_SIZE;
			return STAT_OK;
		endfunction

		function void note_input(logic op, logic [IDX_W-1:0] idx, logic [PIX_W-1:0] pix,
				logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
			scaled_px_t  px;
			int unsigned addr;
			if (op == OP_LOAD) begin
				store[idx] = pix;
				written[idx] = 1'b1;
			end else begin
				px.status = fetch_target(x, y, addr);
				px.pixel = (px.status == STAT_OK) ? store[addr] : '0;
				predicted_px.push_back(px);
			end
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] data);
			scaled_px_t px;
			if (predicted_px.size() == 0) begin
				$display("%0t: result %h with nothing pending", $time, data);
				errors++;
				return;
			end
			px = predicted_px.pop_front();
			if (data[PIX_W-1:0] !== px.pixel) begin
				$display("%0t: out_pixel mismatch, expected %h actual %h",
					$time, px.pixel, data[PIX_W-1:0]);
				errors++;
			end
			if (data[PIX_W +: STAT_W] !== px.status) begin
				$display("%0t: status mismatch, expected %0d actual %0d",
					$time, px.status, data[PIX_W +: STAT_W]);
				errors++;
			end
		endfunction

		function int pending();
			return predicted_px.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// load_index, load_pixel, dest_x, dest_y, zero pad
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	// op
	logic [0:0]            s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// out_pixel, status, zero pad
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [REG_W-1:0]      cfg_data = '0;

	scaler_scoreboard sb = new();
	bit calm = 1'b0;
	int cycles = 0;

	rgb565_nearest_scaler dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	// result side: random stall before each transfer, none while calm
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
			input logic [PIX_W-1:0] pix, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {{(IN_DATA_W - IDX_W - PIX_W - 2 * COORD_W){1'b0}}, y, x, pix, idx};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_input(op, idx, pix, x, y);
	endtask

	// never read an entry that was never written: load it first if needed
	task automatic fetch_px(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
		int unsigned addr;
		logic [31:0] r1, r2;
		r1 = $urandom;
		r2 = $urandom;
		if (sb.fetch_target(x, y, addr) == STAT_OK && !sb.written[addr])
			send_item(OP_LOAD, addr[IDX_W-1:0], r1[PIX_W-1:0], r2[COORD_W-1:0],
				r2[2*COORD_W-1:COORD_W]);
		r1 = $urandom;
		r2 = $urandom;
		send_item(OP_FETCH, r1[IDX_W-1:0], r2[PIX_W-1:0], x, y);
	endtask

	task automatic wait_results_done();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_one(input reg_idx_t idx, input logic [REG_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		sb.write_reg(idx, v);
	endtask

	task automatic configure(input int unsigned sw, input int unsigned sh,
			input int unsigned pitch, input int unsigned dw, input int unsigned dh);
		logic [31:0] r;
		r = $urandom;
		write_one(REG_SRC_W, sw[REG_W-1:0]);
		write_one(REG_SRC_H, sh[REG_W-1:0]);
		write_one(REG_PITCH, pitch[REG_W-1:0]);
		write_one(REG_DST_W, dw[REG_W-1:0]);
		write_one(REG_DST_H, dh[REG_W-1:0]);
		// an index past the register list must change nothing
		write_one(reg_idx_t'(REG_DST_H + 1 + $urandom_range(0, 2)), r[REG_W-1:0]);
		cfg_we <= 1'b0;
	endtask

	task automatic random_items(input int n);
		int unsigned dw, dh, xmax, ymax, extent, pick;
		logic [31:0] r1, r2;
		dw = sb.regs[REG_DST_W];
		dh = sb.regs[REG_DST_H];
		xmax = (dw == 0) ? 0 : (dw > MAX_DIM) ? MAX_DIM - 1 : dw - 1;
		ymax = (dh == 0) ? 0 : (dh > MAX_DIM) ? MAX_DIM - 1 : dh - 1;
		extent = sb.regs[REG_SRC_H] * ((sb.regs[REG_PITCH] < sb.regs[REG_SRC_W]) ?
			sb.regs[REG_SRC_W] : sb.regs[REG_PITCH]);
		if (extent == 0 || extent > STORE_PIXELS_DEF)
			extent = STORE_PIXELS_DEF;
		for (int i = 0; i < n; i++) begin
			if (i % 100 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if (i % 150 == 149)
				wait_results_done();
			pick = $urandom_range(0, 99);
			r1 = $urandom;
			r2 = $urandom;
			if (pick < 25) begin
				if (pick < 12)
					r1 = $urandom_range(0, extent - 1);
				send_item(OP_LOAD, r1[IDX_W-1:0], r2[PIX_W-1:0], r2[COORD_W-1:0],
					r1[31 -: COORD_W]);
			end else if (pick < 88) begin
				fetch_px(COORD_W'($urandom_range(0, xmax)), COORD_W'($urandom_range(0, ymax)));
			end else begin
				fetch_px(r1[COORD_W-1:0], r2[COORD_W-1:0]);
			end
		end
	endtask

	task automatic run_phase(input int unsigned sw, input int unsigned sh,
			input int unsigned pitch, input int unsigned dw, input int unsigned dh,
			input int n);
		logic [COORD_W-1:0] xl, yl, xo;
		wait_results_done();
		configure(sw, sh, pitch, dw, dh);
		xl = (dw == 0) ? 0 : (dw > MAX_DIM) ? MAX_DIM - 1 : dw - 1;
		yl = (dh == 0) ? 0 : (dh > MAX_DIM) ? MAX_DIM - 1 : dh - 1;
		xo = (dw >= MAX_DIM) ? MAX_DIM - 1 : dw;
		// two corners and one column just past the right edge (the last column when dw >= MAX_DIM)
		fetch_px('0, '0);
		fetch_px(xl, yl);
		fetch_px(xo, '0);
		random_items(n);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed checks at the reset register values
		calm = 1'b1;
		send_item(OP_LOAD, '0, '0, '0, '0);
		send_item(OP_LOAD, '1, '1, '1, '1);
		send_item(OP_LOAD, '0, 16'hffff, '0, '0);
		fetch_px(10'd0, 10'd0);
		fetch_px(10'd159, 10'd119);
		fetch_px(10'd80, 10'd60);
		fetch_px(10'd160, 10'd0);
		fetch_px(10'd0, 10'd120);
		fetch_px('1, '1);
		calm = 1'b0;
		fetch_px(10'd1, 10'd118);
		fetch_px(10'd158, 10'd1);

		run_phase(16, 12, 16, 8, 6, 250);
		// pitch zero is raised to the width, single destination pixel takes the centre
		run_phase(1, 1, 0, 1, 1, 60);
		// widest source filling the store exactly
		run_phase(1024, 128, 1024, 1024, 2, 250);
		run_phase(64, 1024, 100, 3, 1024, 250);
		// upscale with the largest pitch
		run_phase(5, 7, 2047, 37, 50, 200);
		run_phase(320, 240, 200, 1, 1024, 150);
		// bad sizes and oversized frames win over range errors
		run_phase(0, 240, 320, 160, 120, 40);
		run_phase(320, 2047, 320, 160, 120, 40);
		run_phase(320, 240, 320, 0, 1025, 40);
		run_phase(1024, 129, 0, 64, 64, 40);
		run_phase(2047, 1, 2047, 2047, 1024, 40);
		run_phase(100, 80, 128, 200, 160, 250);

		wait_results_done();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
